### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bus decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define MBD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent
`define MBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and codes of the memory bus decoder with access locks.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int DATA_W = 8;
   localparam int ADDR_W = 16;

   // Transaction kinds
   typedef enum logic [1:0] {
      OP_READ       = 2'd0,
      OP_WRITE      = 2'd1,
      OP_LOCK_SET   = 2'd2,
      OP_LOCK_CLEAR = 2'd3
   } op_type;

   // Where an access went
   typedef enum logic [2:0] {
      ROUTE_INTERNAL = 3'd0,
      ROUTE_CART     = 3'd1,
      ROUTE_IO       = 3'd2,
      ROUTE_UNMAPPED = 3'd3,
      ROUTE_BLOCKED  = 3'd4
   } route_type;

   // Requesters
   localparam logic [1:0] SRC_PICTURE  = 2'd1;
   localparam logic [1:0] SRC_TRANSFER = 2'd2;

   // Lock selectors
   localparam logic [1:0] LOCK_VIDEO    = 2'd0;
   localparam logic [1:0] LOCK_OBJECT   = 2'd1;
   localparam logic [1:0] LOCK_TRANSFER = 2'd2;

   // Fixed read answers
   localparam logic [DATA_W-1:0] BLOCKED_READ  = 8'hFF;
   localparam logic [DATA_W-1:0] UNMAPPED_READ = 8'h00;

   // Control of one memory port
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [DATA_W-1:0] wr_data;
   } ram_ctl_type;

endpackage

### rtl/core/memory_bus_decoder_with_locks.sv
// ----------------------------------------------------------------------------
// memory_bus_decoder_with_locks
// Address decoder for the console bus: serves video, work, object and high
// memories, forwards cartridge and I/O transactions, and gates by locks.
// ----------------------------------------------------------------------------
// Result: valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while rsp_tready is high and no
// clearing pass runs; each memory does one access per cycle through its
// single port, and its registered read sets the latency. Reset: synchronous;
// locks clear at once, then a clearing pass zeroes all memories across
// max(VIDEO_DEPTH, WORK_DEPTH) addresses (8192 by default) with req_tready low.
`include "assert_macros.svh"

module memory_bus_decoder_with_locks #(
   parameter int VIDEO_DEPTH  = 8192,
   parameter int WORK_DEPTH   = 8192,
   parameter int OBJECT_DEPTH = 160,
   parameter int HIGH_DEPTH   = 127
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   // address[15:0], write_data[23:16], source[25:24], lock_target[27:26]
   input  logic [31:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], forward_write[8], forward_address[24:9],
   // forward_data[32:25]
   output logic [39:0] rsp_tdata,
   // route[2:0]
   output logic [2:0]  rsp_tuser
);

   localparam int VIDEO_AW  = $clog2(VIDEO_DEPTH);
   localparam int WORK_AW   = $clog2(WORK_DEPTH);
   localparam int OBJECT_AW = $clog2(OBJECT_DEPTH);
   localparam int HIGH_AW   = $clog2(HIGH_DEPTH);
   localparam int MAX_DEPTH = (VIDEO_DEPTH > WORK_DEPTH) ? VIDEO_DEPTH : WORK_DEPTH;
   localparam int CLR_W     = $clog2(MAX_DEPTH);

   typedef enum logic [2:0] {
      REGION_CART,
      REGION_VIDEO,
      REGION_WORK,
      REGION_OBJECT,
      REGION_IO,
      REGION_HIGH,
      REGION_NONE
   } region_type;

   typedef enum logic [2:0] {
      SEL_CONST,
      SEL_VIDEO,
      SEL_WORK,
      SEL_OBJECT,
      SEL_HIGH
   } sel_type;

   // Request fields
   mbd_pkg::op_type              op;
   logic [15:0]                  addr;
   logic [7:0]                   wdata;
   logic [1:0]                   src;
   logic [1:0]                   tgt;
   logic                         accept;
   logic                         is_wr;
   logic                         dma_block;
   region_type                   region;

   // Offsets into each memory
   logic [15:0]                  video_off;
   logic [15:0]                  work_off;
   logic [15:0]                  object_off;
   logic [15:0]                  high_off;

   logic                         video_acc;
   logic                         work_acc;
   logic                         object_acc;
   logic                         high_acc;

   // Control and pipeline registers
   logic                         valid_ff, valid_in;
   logic                         clearing_ff, clearing_in;
   logic [CLR_W-1:0]             clr_cnt_ff, clr_cnt_in;
   logic                         video_lock_ff, video_lock_in;
   logic                         object_lock_ff, object_lock_in;
   logic                         transfer_lock_ff, transfer_lock_in;
   mbd_pkg::route_type           route_ff, route_in;
   sel_type                      sel_ff, sel_in;
   logic [7:0]                   rd_const_ff, rd_const_in;
   logic                         fwd_write_ff, fwd_write_in;
   logic [15:0]                  fwd_addr_ff, fwd_addr_in;
   logic [7:0]                   fwd_data_ff, fwd_data_in;

   // Memory ports
   mbd_pkg::ram_ctl_type         video_ctl, work_ctl, object_ctl, high_ctl;
   logic [VIDEO_AW-1:0]          video_addr;
   logic [WORK_AW-1:0]           work_addr;
   logic [OBJECT_AW-1:0]         object_addr;
   logic [HIGH_AW-1:0]           high_addr;
   logic [7:0]                   video_q, work_q, object_q, high_q;
   logic [7:0]                   read_data;

   // Unpack the request
   assign op     = mbd_pkg::op_type'(req_tuser);
   assign addr   = req_tdata[15:0];
   assign wdata  = req_tdata[23:16];
   assign src    = req_tdata[25:24];
   assign tgt    = req_tdata[27:26];

   // Take a transaction when the result slot frees up, never while clearing
   assign req_tready = !clearing_ff && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_wr      = (op == mbd_pkg::OP_WRITE);
   assign dma_block  = transfer_lock_ff && (src != mbd_pkg::SRC_TRANSFER);

   assign video_off  = {3'b000, addr[12:0]};
   assign work_off   = {3'b000, addr[12:0]};
   assign object_off = {8'h00, addr[7:0]};
   assign high_off   = {9'h000, addr[6:0]};

   // Decode the address map
   always_comb begin
      if (!addr[15] || (addr[15:13] == 3'b101)) begin
         region = REGION_CART;
      end else if (addr[15:13] == 3'b100) begin
         region = REGION_VIDEO;
      end else if (addr[15:13] == 3'b110) begin
         region = REGION_WORK;
      end else if ((addr[15:8] == 8'hFE) && (addr[7:0] < 8'hA0)) begin
         region = REGION_OBJECT;
      end else if ((addr[15:7] == 9'h1FE) || (addr == 16'hFFFF)) begin
         region = REGION_IO;
      end else if (addr[15:7] == 9'h1FF) begin
         region = REGION_HIGH;
      end else begin
         region = REGION_NONE;
      end
   end

   // Gate, route and pick the read source
   always_comb begin
      route_in     = mbd_pkg::ROUTE_INTERNAL;
      sel_in       = SEL_CONST;
      rd_const_in  = 8'h00;
      fwd_write_in = 1'b0;
      fwd_addr_in  = 16'h0000;
      fwd_data_in  = 8'h00;
      video_acc    = 1'b0;
      work_acc     = 1'b0;
      object_acc   = 1'b0;
      high_acc     = 1'b0;
      if ((op == mbd_pkg::OP_READ) || (op == mbd_pkg::OP_WRITE)) begin
         unique case (region)
            REGION_CART: begin
               route_in = dma_block ? mbd_pkg::ROUTE_BLOCKED : mbd_pkg::ROUTE_CART;
            end
            REGION_VIDEO: begin
               if (dma_block || (video_lock_ff && (src != mbd_pkg::SRC_PICTURE))) begin
                  route_in = mbd_pkg::ROUTE_BLOCKED;
               end else if ({1'b0, video_off} >= 17'(VIDEO_DEPTH)) begin
                  route_in = mbd_pkg::ROUTE_UNMAPPED;
               end else begin
                  video_acc = 1'b1;
                  sel_in    = is_wr ? SEL_CONST : SEL_VIDEO;
               end
            end
            REGION_WORK: begin
               if (dma_block) begin
                  route_in = mbd_pkg::ROUTE_BLOCKED;
               end else if ({1'b0, work_off} >= 17'(WORK_DEPTH)) begin
                  route_in = mbd_pkg::ROUTE_UNMAPPED;
               end else begin
                  work_acc = 1'b1;
                  sel_in   = is_wr ? SEL_CONST : SEL_WORK;
               end
            end
            REGION_OBJECT: begin
               if (dma_block || (object_lock_ff && (src != mbd_pkg::SRC_PICTURE)
                                 && (src != mbd_pkg::SRC_TRANSFER))) begin
                  route_in = mbd_pkg::ROUTE_BLOCKED;
               end else if ({1'b0, object_off} >= 17'(OBJECT_DEPTH)) begin
                  route_in = mbd_pkg::ROUTE_UNMAPPED;
               end else begin
                  object_acc = 1'b1;
                  sel_in     = is_wr ? SEL_CONST : SEL_OBJECT;
               end
            end
            REGION_IO: begin
               route_in = mbd_pkg::ROUTE_IO;
            end
            REGION_HIGH: begin
               if ({1'b0, high_off} >= 17'(HIGH_DEPTH)) begin
                  route_in = mbd_pkg::ROUTE_UNMAPPED;
               end else begin
                  high_acc = 1'b1;
                  sel_in   = is_wr ? SEL_CONST : SEL_HIGH;
               end
            end
            default: begin
               route_in = mbd_pkg::ROUTE_UNMAPPED;
            end
         endcase
         // Fixed answers and forwarded fields
         if (route_in == mbd_pkg::ROUTE_BLOCKED) begin
            rd_const_in = is_wr ? 8'h00 : mbd_pkg::BLOCKED_READ;
         end else if (route_in == mbd_pkg::ROUTE_UNMAPPED) begin
            rd_const_in = mbd_pkg::UNMAPPED_READ;
         end else if ((route_in == mbd_pkg::ROUTE_CART) || (route_in == mbd_pkg::ROUTE_IO)) begin
            fwd_write_in = is_wr;
            fwd_addr_in  = addr;
            fwd_data_in  = is_wr ? wdata : 8'h00;
         end
      end
   end

   // Next lock values
   always_comb begin
      video_lock_in    = video_lock_ff;
      object_lock_in   = object_lock_ff;
      transfer_lock_in = transfer_lock_ff;
      if (accept && ((op == mbd_pkg::OP_LOCK_SET) || (op == mbd_pkg::OP_LOCK_CLEAR))) begin
         case (tgt)
            mbd_pkg::LOCK_VIDEO:    video_lock_in    = (op == mbd_pkg::OP_LOCK_SET);
            mbd_pkg::LOCK_OBJECT:   object_lock_in   = (op == mbd_pkg::OP_LOCK_SET);
            mbd_pkg::LOCK_TRANSFER: transfer_lock_in = (op == mbd_pkg::OP_LOCK_SET);
            default: ;
         endcase
      end
   end

   // Advance the clearing sweep and the result slot
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_W'(MAX_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
      valid_in = accept || (valid_ff && !rsp_tready);
   end

   // Drive memory ports: zero sweep after reset, else the accepted transaction
   always_comb begin
      if (clearing_ff) begin
         video_ctl.wr_en  = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(VIDEO_DEPTH));
         work_ctl.wr_en   = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(WORK_DEPTH));
         object_ctl.wr_en = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(OBJECT_DEPTH));
         high_ctl.wr_en   = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(HIGH_DEPTH));
         video_ctl.wr_data  = 8'h00;
         work_ctl.wr_data   = 8'h00;
         object_ctl.wr_data = 8'h00;
         high_ctl.wr_data   = 8'h00;
         video_addr  = clr_cnt_ff[VIDEO_AW-1:0];
         work_addr   = clr_cnt_ff[WORK_AW-1:0];
         object_addr = clr_cnt_ff[OBJECT_AW-1:0];
         high_addr   = clr_cnt_ff[HIGH_AW-1:0];
      end else begin
         video_ctl.wr_en  = accept && video_acc && is_wr;
         work_ctl.wr_en   = accept && work_acc && is_wr;
         object_ctl.wr_en = accept && object_acc && is_wr;
         high_ctl.wr_en   = accept && high_acc && is_wr;
         video_ctl.wr_data  = wdata;
         work_ctl.wr_data   = wdata;
         object_ctl.wr_data = wdata;
         high_ctl.wr_data   = wdata;
         video_addr  = video_off[VIDEO_AW-1:0];
         work_addr   = work_off[WORK_AW-1:0];
         object_addr = object_off[OBJECT_AW-1:0];
         high_addr   = high_off[HIGH_AW-1:0];
      end
      video_ctl.rd_en  = accept && video_acc && !is_wr;
      work_ctl.rd_en   = accept && work_acc && !is_wr;
      object_ctl.rd_en = accept && object_acc && !is_wr;
      high_ctl.rd_en   = accept && high_acc && !is_wr;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= 1'b0;
         clearing_ff      <= 1'b1;
         clr_cnt_ff       <= '0;
         video_lock_ff    <= 1'b0;
         object_lock_ff   <= 1'b0;
         transfer_lock_ff <= 1'b0;
      end else begin
         valid_ff         <= valid_in;
         clearing_ff      <= clearing_in;
         clr_cnt_ff       <= clr_cnt_in;
         video_lock_ff    <= video_lock_in;
         object_lock_ff   <= object_lock_in;
         transfer_lock_ff <= transfer_lock_in;
      end
   end

   // Capture the result payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         route_ff     <= route_in;
         sel_ff       <= sel_in;
         rd_const_ff  <= rd_const_in;
         fwd_write_ff <= fwd_write_in;
         fwd_addr_ff  <= fwd_addr_in;
         fwd_data_ff  <= fwd_data_in;
      end
   end

   mbd_ram #(.DEPTH(VIDEO_DEPTH), .ADDR_W(VIDEO_AW)) u_video_ram (
      .clock   (clock),
      .ctl     (video_ctl),
      .addr    (video_addr),
      .rd_data (video_q)
   );

   mbd_ram #(.DEPTH(WORK_DEPTH), .ADDR_W(WORK_AW)) u_work_ram (
      .clock   (clock),
      .ctl     (work_ctl),
      .addr    (work_addr),
      .rd_data (work_q)
   );

   mbd_ram #(.DEPTH(OBJECT_DEPTH), .ADDR_W(OBJECT_AW)) u_object_ram (
      .clock   (clock),
      .ctl     (object_ctl),
      .addr    (object_addr),
      .rd_data (object_q)
   );

   mbd_ram #(.DEPTH(HIGH_DEPTH), .ADDR_W(HIGH_AW)) u_high_ram (
      .clock   (clock),
      .ctl     (high_ctl),
      .addr    (high_addr),
      .rd_data (high_q)
   );

   // Select the read byte
   always_comb begin
      case (sel_ff)
         SEL_VIDEO:  read_data = video_q;
         SEL_WORK:   read_data = work_q;
         SEL_OBJECT: read_data = object_q;
         SEL_HIGH:   read_data = high_q;
         default:    read_data = rd_const_ff;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0000000, fwd_data_ff, fwd_addr_ff, fwd_write_ff, read_data};
   assign rsp_tuser  = route_ff;

   // Checks
   `MBD_ASSERT_SAME(a_clear_no_result, clock, reset, clearing_ff, !valid_ff, "result pending during memory clear")
   `MBD_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, valid_ff, "accepted transaction produced no result")
   `MBD_ASSERT_NEXT(a_video_lock_blocks, clock, reset, accept && (region == REGION_VIDEO) && video_lock_ff && (src != mbd_pkg::SRC_PICTURE) && ((op == mbd_pkg::OP_READ) || (op == mbd_pkg::OP_WRITE)), route_ff == mbd_pkg::ROUTE_BLOCKED, "locked video access not blocked")
   `MBD_ASSERT_SAME(a_fwd_only_routed, clock, reset, valid_ff && (route_ff != mbd_pkg::ROUTE_CART) && (route_ff != mbd_pkg::ROUTE_IO), !fwd_write_ff && (fwd_addr_ff == 16'h0000), "forward fields set on a local route")
   `MBD_ASSERT_SAME(a_blocked_no_memory, clock, reset, valid_ff && (route_ff == mbd_pkg::ROUTE_BLOCKED), sel_ff == SEL_CONST, "blocked transaction read a memory")

endmodule

### rtl/core/mbd_ram.sv
// ----------------------------------------------------------------------------
// mbd_ram
// Single-port byte memory with a registered read port.
// ----------------------------------------------------------------------------
module mbd_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                      clock,
   input  mbd_pkg::ram_ctl_type      ctl,
   input  logic [ADDR_W-1:0]         addr,
   output logic [mbd_pkg::DATA_W-1:0] rd_data
);

   logic [mbd_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [mbd_pkg::DATA_W-1:0] rd_data_ff;

   // Write or read one byte per cycle; hold read data otherwise
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
